// ===== rtl/core/tps_pkg.sv =====
package tps_pkg;

  localparam int COORD_W   = 16;
  localparam int PERIM_W   = 19;
  localparam int ENTRY_W   = 4;
  localparam int CFG_W     = 5;
  localparam int ROOT_W    = 17;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int IN_DATA_W = 6 * COORD_W;
  localparam int OUT_DATA_W = 120;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  // first member lands in the high bits: ax ends up lowest
  typedef struct packed {
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] ax;
  } tri_t;

  typedef enum logic [1:0] {
    PAIR_AB,
    PAIR_AC,
    PAIR_BC
  } pair_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_STORE,
    ST_SORT_LDI,
    ST_SORT_CUR,
    ST_SORT_CMP,
    ST_SORT_WRI,
    ST_EM_RDK,
    ST_EM_RDP,
    ST_EM_OUT
  } state_t;

endpackage

// ===== rtl/core/tps_ram.sv =====
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tps_sqrt.sv =====
module tps_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tps_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [tps_pkg::ROOT_W-1:0] root
);

  import tps_pkg::*;

  localparam int STEPS = RAD_W / 2;
  localparam int SC_W  = $clog2(STEPS + 1);

  logic                busy_r;
  logic                done_r;
  logic [SC_W-1:0]     cnt_r;
  logic [RAD_W-1:0]    rad_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   test;
  logic                ge;

  // one result bit per cycle: bring down two radicand bits, try 4*root+1
  assign trial = {rem_r[ROOT_W:0], rad_r[RAD_W-1 -: 2]};
  assign test  = {1'b0, root_r, 2'b01};
  assign ge    = (trial >= test);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SC_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (ROOT_W+2)'(trial - test) : (ROOT_W+2)'(trial);
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/triangle_perimeter_sorter.sv =====
// Channel  Dir  Signals                        Contents
// in_      in   in_tvalid/tready/tdata[95:0]   one triangle, three Q8.8 points
// out_     out  out_tvalid/tready/tdata/tlast  sorted triangle, index, perimeter
// cfg_     in   cfg_we, cfg_wdata[4:0]         triangle_count
//
// Load: each item goes through the shared square-root unit
// (17 steps per distance, three distances in turn, plus squaring stages);
// in_tready is low outside idle. Sort: compare-and-swap passes through the key RAM.
// Emit: key read, point read, output load; out_tready low holds the output register.
// Reset: synchronous, active low; RAM contents are not cleared.
module triangle_perimeter_sorter #(
  parameter int MAX_TRIANGLES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // ax, ay, bx, by, cx, cy
  input  logic [tps_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // entry_index, out_ax, out_ay, out_bx, out_by, out_cx, out_cy, perimeter, zero pad
  output logic [tps_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [tps_pkg::CFG_W-1:0]      cfg_wdata
);

  import tps_pkg::*;

  localparam int IDX_W = $clog2(MAX_TRIANGLES);
  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam int KEY_W = PERIM_W + IDX_W;
  localparam logic [8:0] MAX9 = 9'(MAX_TRIANGLES);

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     cfg_r;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  tri_t                 tri_r, tri_nxt;
  pair_t                pair_r, pair_nxt;
  logic [COORD_W-1:0]   ux_r, ux_nxt, uy_r, uy_nxt;
  logic [SQ_W-1:0]      sqa_r, sqa_nxt, sqb_r, sqb_nxt;
  logic [PERIM_W-1:0]   perim_r, perim_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [KEY_W-1:0]     cur_r, cur_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;
  tri_t                 out_tri_r, out_tri_nxt;
  logic [PERIM_W-1:0]   out_perim_r, out_perim_nxt;
  logic [ENTRY_W-1:0]   out_idx_r, out_idx_nxt;

  logic [CNT_W-1:0]     target;
  logic                 out_load;

  logic                 k_we, k_re;
  logic [IDX_W-1:0]     k_waddr, k_raddr;
  logic [KEY_W-1:0]     k_wdata, k_rdata;
  logic                 p_we, p_re;
  logic [IDX_W-1:0]     p_raddr;
  tri_t                 p_rdata;

  logic                 sq_start, sq_done;
  logic [RAD_W-1:0]     sq_rad;
  logic [ROOT_W-1:0]    sq_root;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      px, py, qx, qy;

  // count of zero acts as one, above the store depth acts as the depth
  always_comb begin
    if (cfg_r == '0) begin
      target = CNT_W'(1);
    end else if ({4'b0, cfg_r} > MAX9) begin
      target = CNT_W'(MAX_TRIANGLES);
    end else begin
      target = CNT_W'(cfg_r);
    end
  end

  tps_ram #(.WIDTH(IN_DATA_W), .DEPTH(MAX_TRIANGLES)) u_point_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (IDX_W'(fill_r)),
    .wdata (in_tdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  tps_ram #(.WIDTH(KEY_W), .DEPTH(MAX_TRIANGLES)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  tps_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    case (pair_r)
      PAIR_AB: begin
        px = tri_r.ax; py = tri_r.ay; qx = tri_r.bx; qy = tri_r.by;
      end
      PAIR_AC: begin
        px = tri_r.ax; py = tri_r.ay; qx = tri_r.cx; qy = tri_r.cy;
      end
      default: begin
        px = tri_r.bx; py = tri_r.by; qx = tri_r.cx; qy = tri_r.cy;
      end
    endcase
    dx = $signed({px[COORD_W-1], px}) - $signed({qx[COORD_W-1], qx});
    dy = $signed({py[COORD_W-1], py}) - $signed({qy[COORD_W-1], qy});
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    tri_nxt       = tri_r;
    pair_nxt      = pair_r;
    ux_nxt        = ux_r;
    uy_nxt        = uy_r;
    sqa_nxt       = sqa_r;
    sqb_nxt       = sqb_r;
    perim_nxt     = perim_r;
    slot_nxt      = slot_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_tri_nxt   = out_tri_r;
    out_perim_nxt = out_perim_r;
    out_idx_nxt   = out_idx_r;
    out_load      = 1'b0;
    k_we          = 1'b0;
    k_waddr       = slot_r;
    k_wdata       = {perim_r, slot_r};
    k_re          = 1'b0;
    k_raddr       = i_r;
    p_we          = 1'b0;
    p_re          = 1'b0;
    p_raddr       = k_rdata[IDX_W-1:0];
    sq_start      = 1'b0;
    sq_rad        = RAD_W'(sqa_r) + RAD_W'(sqb_r);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          p_we      = 1'b1;
          tri_nxt   = tri_t'(in_tdata);
          slot_nxt  = IDX_W'(fill_r);
          pair_nxt  = PAIR_AB;
          perim_nxt = '0;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ux_nxt    = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
        uy_nxt    = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        sqa_nxt   = ux_r * ux_r;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        sqb_nxt   = uy_r * uy_r;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          perim_nxt = perim_r + PERIM_W'(sq_root);
          case (pair_r)
            PAIR_AB: begin
              pair_nxt  = PAIR_AC;
              state_nxt = ST_DIFF;
            end
            PAIR_AC: begin
              pair_nxt  = PAIR_BC;
              state_nxt = ST_DIFF;
            end
            default: begin
              state_nxt = ST_STORE;
            end
          endcase
        end
      end
      ST_STORE: begin
        k_we     = 1'b1;
        fill_nxt = CNT_W'(slot_r) + CNT_W'(1);
        if (fill_nxt >= target) begin
          i_nxt = '0;
          k_nxt = '0;
          state_nxt = (slot_r == '0) ? ST_EM_RDK : ST_SORT_LDI;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SORT_LDI: begin
        k_re      = 1'b1;
        k_raddr   = i_r;
        state_nxt = ST_SORT_CUR;
      end
      ST_SORT_CUR: begin
        cur_nxt   = k_rdata;
        k_re      = 1'b1;
        k_raddr   = i_r + 1'b1;
        j_nxt     = i_r + 1'b1;
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        // entry i lives in cur_r until its pass ends; swap only on strictly greater
        if (cur_r[KEY_W-1 -: PERIM_W] > k_rdata[KEY_W-1 -: PERIM_W]) begin
          k_we    = 1'b1;
          k_waddr = j_r;
          k_wdata = cur_r;
          cur_nxt = k_rdata;
        end
        if (j_r == slot_r) begin
          state_nxt = ST_SORT_WRI;
        end else begin
          k_re    = 1'b1;
          k_raddr = j_r + 1'b1;
          j_nxt   = j_r + 1'b1;
        end
      end
      ST_SORT_WRI: begin
        k_we    = 1'b1;
        k_waddr = i_r;
        k_wdata = cur_r;
        i_nxt   = i_r + 1'b1;
        if (i_nxt == slot_r) begin
          k_nxt     = '0;
          state_nxt = ST_EM_RDK;
        end else begin
          k_re      = 1'b1;
          k_raddr   = i_nxt;
          state_nxt = ST_SORT_CUR;
        end
      end
      ST_EM_RDK: begin
        k_re      = 1'b1;
        k_raddr   = k_r;
        state_nxt = ST_EM_RDP;
      end
      ST_EM_RDP: begin
        p_re      = 1'b1;
        state_nxt = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        // key read data holds here since no key read is issued
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_tri_nxt   = p_rdata;
          out_perim_nxt = k_rdata[KEY_W-1 -: PERIM_W];
          out_idx_nxt   = ENTRY_W'(k_rdata[IDX_W-1:0]);
          out_last_nxt  = (k_r == slot_r);
          if (k_r == slot_r) begin
            fill_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_EM_RDK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      pair_r      <= PAIR_AB;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pair_r      <= pair_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tri_r       <= tri_nxt;
    ux_r        <= ux_nxt;
    uy_r        <= uy_nxt;
    sqa_r       <= sqa_nxt;
    sqb_r       <= sqb_nxt;
    perim_r     <= perim_nxt;
    slot_r      <= slot_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    out_last_r  <= out_last_nxt;
    out_tri_r   <= out_tri_nxt;
    out_perim_r <= out_perim_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_perim_r, out_tri_r, out_idx_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (fill_r < CNT_W'(MAX_TRIANGLES)))
    else $error("fill count reached store depth while idle");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == ST_ROOT))
    else $error("square root finished outside its wait state");

  a_sort_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT_CMP) |-> ((j_r > i_r) && (j_r <= slot_r)))
    else $error("sort compare index out of range");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> ((state_r == ST_IDLE) && (fill_r == '0)))
    else $error("run did not restart after last result");

endmodule
